FILE: rtl/btpl_pkg.sv
package btpl_pkg;

  // Field widths of one word on either side
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned PORT_W     = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned PORT_EXT_W = 16;

  // Operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_HIT  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

  // Classified command handed from the front to the engine
  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  prefix_len;
    logic [PORT_W-1:0] port;
  } cmd_t;

  // Result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PORT_W-1:0]   out_port;
    logic [LEN_W-1:0]    match_len;
  } res_t;

endpackage

FILE: rtl/btpl_ram.sv
module btpl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, hold data while not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/btpl_fifo.sv
module btpl_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/btpl_front.sv
module btpl_front
  import btpl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              op_i,
  input  logic [ADDR_W-1:0] address_i,
  input  logic [LEN_W-1:0]  prefix_len_i,
  input  logic [PORT_W-1:0] port_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  cmd_t cmd_in;
  logic cmd_empty;

  // Classify: clamp an over-long prefix to the full address width
  always_comb begin
    cmd_in.op         = op_i;
    cmd_in.address    = address_i;
    cmd_in.port       = port_i;
    cmd_in.prefix_len = (prefix_len_i > LEN_W'(ADDR_W)) ? LEN_W'(ADDR_W) : prefix_len_i;
  end

  // Short command queue toward the engine
  btpl_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

FILE: rtl/btpl_engine.sv
module btpl_engine
  import btpl_pkg::*;
#(
  parameter int unsigned NODE_COUNT = 4096,
  parameter int unsigned PORT_BITS  = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  localparam int unsigned IDX_W = $clog2(NODE_COUNT);
  localparam int unsigned CNT_W = IDX_W + 1;

  typedef struct packed {
    logic [IDX_W-1:0]     zero_child;
    logic [IDX_W-1:0]     one_child;
    logic                 route_valid;
    logic [PORT_BITS-1:0] route_port;
    logic [LEN_W-1:0]     route_len;
  } node_t;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_ALLOC = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic                 op_q, op_d;
  logic [ADDR_W-1:0]    bits_q, bits_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [PORT_BITS-1:0] port_q, port_d;
  logic [LEN_W-1:0]     depth_q, depth_d;
  logic [IDX_W-1:0]     node_q, node_d;
  logic [CNT_W-1:0]     used_q, used_d;
  node_t                root_q, root_d;
  logic                 found_q, found_d;
  logic [PORT_BITS-1:0] best_port_q, best_port_d;
  logic [LEN_W-1:0]     best_len_q, best_len_d;
  logic [STATUS_W-1:0]  status_q, status_d;

  node_t                 rd_ent, wr_ent, cur, upd;
  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic                  bit_sel;
  logic [IDX_W-1:0]      child, new_idx;
  logic [CNT_W-1:0]      need, room;
  logic [PORT_EXT_W-1:0] port_ext, best_ext;

  // Root lives in flops, all other nodes in the pool memory
  assign cur      = (node_q == '0) ? root_q : rd_ent;
  assign bit_sel  = bits_q[ADDR_W-1];
  assign child    = bit_sel ? cur.one_child : cur.zero_child;
  assign new_idx  = used_q[IDX_W-1:0];
  assign need     = CNT_W'(len_q) - CNT_W'(depth_q);
  assign room     = CNT_W'(NODE_COUNT) - used_q;
  assign port_ext = PORT_EXT_W'(cmd_i.port);
  assign best_ext = PORT_EXT_W'(best_port_q);

  // Sequencer: one trie level per cycle
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    bits_d      = bits_q;
    len_d       = len_q;
    port_d      = port_q;
    depth_d     = depth_q;
    node_d      = node_q;
    used_d      = used_q;
    root_d      = root_q;
    found_d     = found_q;
    best_port_d = best_port_q;
    best_len_d  = best_len_q;
    status_d    = status_q;
    ram_we      = 1'b0;
    ram_waddr   = node_q;
    wr_ent      = cur;
    ram_re      = 1'b0;
    ram_raddr   = child;
    upd         = cur;
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        if (cmd_valid_i) begin
          op_d        = cmd_i.op;
          bits_d      = cmd_i.address;
          len_d       = cmd_i.prefix_len;
          port_d      = port_ext[PORT_BITS-1:0];
          depth_d     = '0;
          node_d      = '0;
          found_d     = 1'b0;
          best_port_d = '0;
          best_len_d  = '0;
          state_d     = S_WALK;
        end
      end

      S_WALK: begin
        if (op_q == OP_LOOKUP) begin
          // Remember the deepest route passed
          if (cur.route_valid) begin
            found_d     = 1'b1;
            best_port_d = cur.route_port;
            best_len_d  = cur.route_len;
          end
          if (depth_q == LEN_W'(ADDR_W) || child == '0) begin
            status_d = found_d ? ST_HIT : ST_MISS;
            state_d  = S_DONE;
          end else begin
            ram_re  = 1'b1;
            node_d  = child;
            bits_d  = bits_q << 1;
            depth_d = depth_q + LEN_W'(1);
          end
        end else if (depth_q == len_q) begin
          // Target node exists: overwrite its route
          upd.route_valid = 1'b1;
          upd.route_port  = port_q;
          upd.route_len   = len_q;
          if (node_q == '0) begin
            root_d = upd;
          end else begin
            ram_we = 1'b1;
            wr_ent = upd;
          end
          status_d = ST_DONE;
          state_d  = S_DONE;
        end else if (child != '0) begin
          ram_re  = 1'b1;
          node_d  = child;
          bits_d  = bits_q << 1;
          depth_d = depth_q + LEN_W'(1);
        end else if (need > room) begin
          status_d = ST_FULL;
          state_d  = S_DONE;
        end else begin
          // Link the first new node below the last existing one
          if (bit_sel) begin
            upd.one_child = new_idx;
          end else begin
            upd.zero_child = new_idx;
          end
          if (node_q == '0) begin
            root_d = upd;
          end else begin
            ram_we = 1'b1;
            wr_ent = upd;
          end
          node_d  = new_idx;
          bits_d  = bits_q << 1;
          depth_d = depth_q + LEN_W'(1);
          state_d = S_ALLOC;
        end
      end

      S_ALLOC: begin
        // Write one fresh node per cycle, chained to the next one; the last holds the route
        wr_ent    = '0;
        ram_we    = 1'b1;
        ram_waddr = node_q;
        used_d    = used_q + CNT_W'(1);
        if (depth_q == len_q) begin
          wr_ent.route_valid = 1'b1;
          wr_ent.route_port  = port_q;
          wr_ent.route_len   = len_q;
          status_d           = ST_DONE;
          state_d            = S_DONE;
        end else begin
          if (bit_sel) begin
            wr_ent.one_child = node_q + IDX_W'(1);
          end else begin
            wr_ent.zero_child = node_q + IDX_W'(1);
          end
          node_d  = node_q + IDX_W'(1);
          bits_d  = bits_q << 1;
          depth_d = depth_q + LEN_W'(1);
        end
      end

      S_DONE: begin
        res_push_o = !res_full_i;
        if (!res_full_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result word: port and length stay zero unless a lookup hit
  assign res_o.status    = status_q;
  assign res_o.out_port  = best_ext[PORT_W-1:0];
  assign res_o.match_len = best_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= CNT_W'(1);
      root_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      root_q  <= root_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    bits_q      <= bits_d;
    len_q       <= len_d;
    port_q      <= port_d;
    depth_q     <= depth_d;
    node_q      <= node_d;
    found_q     <= found_d;
    best_port_q <= best_port_d;
    best_len_q  <= best_len_d;
    status_q    <= status_d;
  end

  // Node pool
  btpl_ram #(
    .WIDTH ($bits(node_t)),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_ent),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_ent)
  );

  // Pool count stays within the pool and never drops the root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != '0) && (used_q <= CNT_W'(NODE_COUNT)))
    else $error("node count out of range");

  // A lookup walk never writes the pool or the root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && op_q == OP_LOOKUP) |-> (!ram_we && root_d == root_q))
    else $error("lookup modified the trie");

  // Fresh nodes are written exactly at the allocation mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC) |-> (node_q == used_q[IDX_W-1:0] && used_q < CNT_W'(NODE_COUNT)))
    else $error("allocation outside free region");

  // Walk depth never passes the address width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK || state_q == S_ALLOC) |-> (depth_q <= LEN_W'(ADDR_W)))
    else $error("walk depth overrun");

  // A result is only pushed once the walk has finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (state_q == S_DONE && $past(state_q) != S_IDLE))
    else $error("result pushed outside done state");

endmodule

FILE: rtl/binary_trie_prefix_lookup_unit.sv
// IPv4 longest-prefix-match unit on a binary trie held in a node pool of NODE_COUNT
// entries (the root in flops, all other nodes in one RAM with a registered read, so no
// clearing pass follows reset). An insert (op 1) walks the existing nodes of its prefix,
// one level per cycle, then writes one new node per cycle; a lookup (op 0) walks up to 32
// address bits, one pool read per level, and returns the deepest route it passed. The
// engine takes one item at a time; the single pool read per trie level sets its pace. A
// two-word queue at the input and another at the output let the engine work while words
// wait on either side.
module binary_trie_prefix_lookup_unit
  import btpl_pkg::*;
#(
  parameter int unsigned NODE_COUNT = 4096,
  parameter int unsigned PORT_BITS  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                op_i,
  input  logic [ADDR_W-1:0]   address_i,
  input  logic [LEN_W-1:0]    prefix_len_i,
  input  logic [PORT_W-1:0]   port_i,
  output logic                empty,
  input  logic                pop,
  output logic [STATUS_W-1:0] status_o,
  output logic [PORT_W-1:0]   out_port_o,
  output logic [LEN_W-1:0]    match_len_o
);

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  res_t res_in, res_out;
  logic res_push, res_full;

  // Accept and classify
  btpl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .op_i         (op_i),
    .address_i    (address_i),
    .prefix_len_i (prefix_len_i),
    .port_i       (port_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  // Walk the trie
  btpl_engine #(
    .NODE_COUNT (NODE_COUNT),
    .PORT_BITS  (PORT_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Hold results until taken
  btpl_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign status_o    = res_out.status;
  assign out_port_o  = res_out.out_port;
  assign match_len_o = res_out.match_len;

endmodule

FILE: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import btpl_pkg::*;

  localparam int unsigned NODE_COUNT     = 4096;
  localparam int unsigned PORT_BITS      = 8;
  localparam int unsigned STALL_CYCLES   = 400;
  localparam int unsigned TIMEOUT_CYCLES = 3000;
  localparam int unsigned SETTLE_CYCLES  = 60;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam logic [PORT_W-1:0] PORT_MASK = PORT_W'((1 << PORT_BITS) - 1);

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                push         = 1'b0;
  logic                full;
  logic                op_i         = OP_LOOKUP;
  logic [ADDR_W-1:0]   address_i    = '0;
  logic [LEN_W-1:0]    prefix_len_i = '0;
  logic [PORT_W-1:0]   port_i       = '0;
  logic                empty;
  logic                pop          = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [PORT_W-1:0]   out_port_o;
  logic [LEN_W-1:0]    match_len_o;

  binary_trie_prefix_lookup_unit #(
    .NODE_COUNT(NODE_COUNT),
    .PORT_BITS (PORT_BITS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .address_i   (address_i),
    .prefix_len_i(prefix_len_i),
    .port_i      (port_i),
    .empty       (empty),
    .pop         (pop),
    .status_o    (status_o),
    .out_port_o  (out_port_o),
    .match_len_o (match_len_o)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow trie: child links, routes per node, pool fill level
  int unsigned       child0 [NODE_COUNT];
  int unsigned       child1 [NODE_COUNT];
  bit                has_route [NODE_COUNT];
  logic [PORT_W-1:0] node_port [NODE_COUNT];
  logic [LEN_W-1:0]  node_len [NODE_COUNT];
  int unsigned       pool_used = 1;

  // Outcome tallies
  int unsigned stored_count  = 0;
  int unsigned refused_count = 0;
  int unsigned hit_count     = 0;
  int unsigned miss_count    = 0;

  cmd_t        pending_q [$];
  res_t        answer_q [$];
  cmd_t        route_log [$];
  cmd_t        word_out;
  int unsigned error_count    = 0;
  int unsigned words_in       = 0;
  int unsigned tx_gap_max     = 5;
  int unsigned rx_gap_max     = 5;
  int unsigned tx_wait        = 0;
  int unsigned rx_wait        = 0;
  int unsigned rx_hold        = 0;
  int unsigned stall_requests = 0;
  int unsigned stall_served   = 0;
  int unsigned idle_cycles    = 0;
  bit          tx_next;
  bit          rx_next;

  function automatic int unsigned clamp_len(logic [LEN_W-1:0] l);
    return (l > 32) ? 32 : int'(l);
  endfunction

  function automatic logic [ADDR_W-1:0] prefix_mask(int unsigned len);
    return (len == 0) ? '0 : ({ADDR_W{1'b1}} << (32 - len));
  endfunction

  // Apply one word to the shadow trie and return the answer it gives
  function automatic res_t trie_apply(cmd_t c);
    res_t              r;
    int unsigned       len;
    int unsigned       depth;
    int unsigned       node;
    int unsigned       nxt;
    int unsigned       i;
    logic [ADDR_W-1:0] bits;
    r     = '0;
    node  = 0;
    depth = 0;
    bits  = c.address;
    if (c.op == OP_INSERT) begin
      len = clamp_len(c.prefix_len);
      // follow the existing path
      while (depth < len) begin
        nxt = bits[ADDR_W-1] ? child1[node] : child0[node];
        if (nxt == 0) break;
        node  = nxt;
        bits  = bits << 1;
        depth++;
      end
      if (len - depth > NODE_COUNT - pool_used) begin
        r.status = ST_FULL;
        refused_count++;
      end else begin
        // grow the missing tail one node per level
        while (depth < len) begin
          nxt = pool_used;
          pool_used++;
          child0[nxt]    = 0;
          child1[nxt]    = 0;
          has_route[nxt] = 1'b0;
          node_port[nxt] = '0;
          node_len[nxt]  = '0;
          if (bits[ADDR_W-1]) child1[node] = nxt;
          else child0[node] = nxt;
          node  = nxt;
          bits  = bits << 1;
          depth++;
        end
        has_route[node] = 1'b1;
        node_port[node] = c.port & PORT_MASK;
        node_len[node]  = LEN_W'(len);
        r.status = ST_DONE;
        stored_count++;
      end
    end else begin
      // remember the deepest route passed on the way down
      if (has_route[0]) begin
        r.out_port  = node_port[0];
        r.match_len = node_len[0];
      end
      r.status = has_route[0] ? ST_HIT : ST_MISS;
      for (i = 0; i < 32; i++) begin
        nxt = bits[ADDR_W-1] ? child1[node] : child0[node];
        if (nxt == 0) break;
        node = nxt;
        bits = bits << 1;
        if (has_route[node]) begin
          r.status    = ST_HIT;
          r.out_port  = node_port[node];
          r.match_len = node_len[node];
        end
      end
      if (r.status == ST_HIT) hit_count++;
      else miss_count++;
    end
    return r;
  endfunction

  function automatic void note_failure(string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  task automatic add_insert(logic [ADDR_W-1:0] a, int unsigned len, logic [PORT_W-1:0] p);
    cmd_t c;
    c.op         = OP_INSERT;
    c.address    = a;
    c.prefix_len = LEN_W'(len);
    c.port       = p;
    pending_q.push_back(c);
    route_log.push_back(c);
  endtask

  task automatic add_lookup(logic [ADDR_W-1:0] a);
    cmd_t c;
    c.op         = OP_LOOKUP;
    c.address    = a;
    c.prefix_len = LEN_W'($urandom_range(0, 63));
    c.port       = PORT_W'($urandom);
    pending_q.push_back(c);
  endtask

  // One random word: lookups mostly aim at routes already planned so they hit deep
  task automatic add_random(int unsigned insert_pct, int unsigned long_pct);
    int unsigned       kind;
    int unsigned       plen;
    cmd_t              pick;
    logic [ADDR_W-1:0] m;
    kind = $urandom_range(0, 9);
    pick = (route_log.size() > 0) ? route_log[$urandom_range(0, route_log.size() - 1)] : '0;
    plen = clamp_len(pick.prefix_len);
    m    = prefix_mask(plen);
    if ($urandom_range(0, 99) < insert_pct) begin
      if (kind < 2 && route_log.size() > 0) begin
        add_insert(pick.address, pick.prefix_len, PORT_W'($urandom));
      end else if (kind < 4 && route_log.size() > 0) begin
        add_insert((pick.address & m) | ($urandom & ~m),
                   (plen + 8 > 32) ? 32 : plen + $urandom_range(1, 8), PORT_W'($urandom));
      end else if (kind == 4) begin
        add_insert($urandom, $urandom_range(33, 63), PORT_W'($urandom));
      end else begin
        add_insert($urandom, ($urandom_range(0, 99) < long_pct) ? $urandom_range(24, 32)
                                                               : $urandom_range(0, 23),
                   PORT_W'($urandom));
      end
    end else begin
      if (kind < 3 || route_log.size() == 0) add_lookup($urandom);
      else if (kind < 5) add_lookup(pick.address);
      else add_lookup((pick.address & m) | ($urandom & ~m));
    end
  endtask

  // Hold until every planned word has been sent and answered
  task automatic wait_drained();
    while (pending_q.size() != 0 || push || answer_q.size() != 0) @(negedge clk_i);
  endtask

  // Driver: present the next planned word after its drawn gap
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      tx_next = push;
      if (push && !full) begin
        answer_q.push_back(trie_apply(word_out));
        words_in++;
        tx_next = 1'b0;
        tx_wait = $urandom_range(0, tx_gap_max);
      end
      if (!tx_next) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (pending_q.size() > 0) begin
          word_out     = pending_q.pop_front();
          op_i         <= word_out.op;
          address_i    <= word_out.address;
          prefix_len_i <= word_out.prefix_len;
          port_i       <= word_out.port;
          tx_next      = 1'b1;
        end
      end
      push <= tx_next;
    end
  end

  // Monitor: take result words, compare with the oldest answer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      rx_next = pop;
      if (pop && !empty) begin
        if (answer_q.size() == 0) begin
          note_failure($sformatf("unexpected result: status %0d port %0d len %0d",
                                 status_o, out_port_o, match_len_o));
        end else begin
          res_t want;
          want = answer_q.pop_front();
          if (status_o !== want.status || out_port_o !== want.out_port ||
              match_len_o !== want.match_len)
            note_failure($sformatf(
              "status %0d/%0d port %0d/%0d len %0d/%0d (expected/actual)",
              want.status, status_o, want.out_port, out_port_o,
              want.match_len, match_len_o));
        end
        rx_next = 1'b0;
        rx_wait = $urandom_range(0, rx_gap_max);
      end
      // start a long hold-off when one is requested
      if (stall_served != stall_requests) begin
        rx_hold = STALL_CYCLES;
        stall_served++;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        rx_next = 1'b0;
      end else if (!rx_next) begin
        if (rx_wait > 0) rx_wait--;
        else rx_next = 1'b1;
      end
      pop <= rx_next;
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles without a handshake", idle_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned rounds;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty trie, default route, extremes, overwrite, over-long prefix
    add_lookup(32'h0000_0000);
    add_insert(32'h0A00_0000, 8, 8'h01);
    add_lookup(32'h0A7F_0000);
    add_lookup(32'h0B00_0000);
    add_insert(32'hFFFF_FFFF, 0, 8'h11);
    add_lookup(32'h0B00_0000);
    add_insert(32'h0A01_0000, 16, 8'h02);
    add_insert(32'h0A01_0203, 32, 8'hFF);
    add_insert(32'hFFFF_FFFF, 32, 8'h00);
    add_insert(32'h0000_0000, 32, 8'h80);
    add_insert(32'h8000_0000, 1, 8'h55);
    add_insert(32'hC0A8_0001, 63, 8'h7F);
    add_insert(32'h0A00_0000, 8, 8'h03);
    add_insert(32'h5555_5555, 33, 8'hAA);
    add_lookup(32'h0A01_0203);
    add_lookup(32'h0A01_02FF);
    add_lookup(32'h0A7F_0000);
    add_lookup(32'hFFFF_FFFF);
    add_lookup(32'h0000_0000);
    add_lookup(32'h8000_0001);
    add_lookup(32'hC0A8_0001);
    add_lookup(32'h5555_5555);
    add_lookup(32'hAAAA_AAAA);
    add_insert(32'h0A01_FFFF, 16, 8'h09);
    add_lookup(32'h0A01_AB00);
    wait_drained();

    // Random mix with gaps on both sides
    for (n = 0; n < 150; n++) add_random(50, 50);
    wait_drained();

    // Long receiver hold-off while the sender keeps pushing back to back
    tx_gap_max = 0;
    stall_requests++;
    for (n = 0; n < 40; n++) add_random(50, 50);
    wait_drained();

    // No idling on either side
    rx_gap_max = 0;
    for (n = 0; n < 80; n++) add_random(50, 50);
    wait_drained();

    // Fill the pool, mostly with long fresh prefixes, until an insert is refused or 30 rounds have run
    rounds = 0;
    while (refused_count == 0 && rounds < 30) begin
      tx_gap_max = (rounds % 2) ? 5 : 0;
      rx_gap_max = (rounds % 2) ? 0 : 5;
      for (n = 0; n < 20; n++) add_random(80, 100);
      wait_drained();
      rounds++;
    end

    // Keep going with a full pool: refused and reused paths, lookups
    tx_gap_max = 5;
    rx_gap_max = 5;
    for (n = 0; n < 80; n++) add_random(50, 60);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (answer_q.size() != 0)
      note_failure($sformatf("%0d results never arrived", answer_q.size()));
    $display("covered %0d words: %0d inserts stored, %0d refused for a full pool,",
             words_in, stored_count, refused_count);
    $display("  %0d lookup hits, %0d lookup misses; trie holds %0d of %0d nodes",
             hit_count, miss_count, pool_used, NODE_COUNT);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d failures", error_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/btpl_pkg.sv
rtl/btpl_ram.sv
rtl/btpl_fifo.sv
rtl/btpl_front.sv
rtl/btpl_engine.sv
rtl/binary_trie_prefix_lookup_unit.sv
verif/testbench.sv
